FILE: rtl/core/sbq_pkg.sv
// Shared widths, step and register codes, and control/coefficient structs
// for the stereo biquad filter. No dependencies.
package sbq_pkg;

	// Field and state widths
	localparam int COEF_W   = 24;
	localparam int A0_W     = COEF_W - 1;
	localparam int SMP_W    = 16;
	localparam int STATE_W  = 48;
	localparam int FRAC_W   = 16;
	localparam int HALF_W   = STATE_W / 2;
	localparam int OPB_W    = HALF_W + 1;
	localparam int PROD_W   = COEF_W + OPB_W;
	localparam int OUTM_W   = STATE_W - FRAC_W;

	// Numerator accumulator and divider geometry
	localparam int ACC_W      = 74;
	localparam int MAG_W      = ACC_W - 1;
	localparam int QUO_W      = 52;
	localparam int TOP_W      = MAG_W - QUO_W;
	localparam int RADIX_BITS = 4;
	localparam int DIV_STEPS  = QUO_W / RADIX_BITS;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	// Output clamp limits
	localparam logic [OUTM_W-1:0] OUT_POS_MAX = OUTM_W'(32767);
	localparam logic [OUTM_W-1:0] OUT_NEG_MAG = OUTM_W'(32768);

	// Multiply step codes
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_B0    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_B2    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_A1_LO = 3'd2;
	localparam logic [STEP_W-1:0] STEP_A1_HI = 3'd3;
	localparam logic [STEP_W-1:0] STEP_A2_LO = 3'd4;
	localparam logic [STEP_W-1:0] STEP_A2_HI = 3'd5;
	localparam logic [STEP_W-1:0] STEP_LAST  = STEP_A2_HI;

	// Register indexes
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_A0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_A1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_A2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_B0 = 3'd3;
	localparam logic [IDX_W-1:0] REG_B2 = 3'd4;

	localparam logic [A0_W-1:0] A0_RESET = A0_W'(1048576);

	typedef struct packed {
		logic [A0_W-1:0]          a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b2;
	} sbq_coef_t;

	typedef struct packed {
		logic              load;
		logic              clr;
		logic              mul_en;
		logic [STEP_W-1:0] step;
		logic              chk;
		logic              div_en;
		logic              wb;
		logic              ch;
	} sbq_ctl_t;

endpackage

FILE: rtl/core/sbq_datapath.sv
// Shared multiplier, numerator accumulator, radix-16 divider and per-channel
// history for the stereo biquad. Depends on sbq_pkg.
module sbq_datapath import sbq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbq_ctl_t                 ctl,
	input  sbq_coef_t                coef,
	input  logic signed [SMP_W-1:0]  left_sample,
	input  logic signed [SMP_W-1:0]  right_sample,
	output logic signed [SMP_W-1:0]  left_res,
	output logic signed [SMP_W-1:0]  right_res
);

	logic signed [SMP_W-1:0]   smp_q [2];
	logic signed [SMP_W-1:0]   xh_q  [2][2];
	logic signed [STATE_W-1:0] yh_q  [2][2];
	logic signed [SMP_W-1:0]   res_q [2];

	logic signed [COEF_W-1:0]  op_a;
	logic signed [OPB_W-1:0]   op_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [STEP_W-1:0]         prod_step_s1;
	logic                      prod_vld_s1;

	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   term;
	logic                      sub;

	logic [ACC_W-1:0]          acc_abs;
	logic [A0_W-1:0]           dvs;
	logic                      ovf_c;
	logic [QUO_W-1:0]          shreg_q;
	logic [A0_W-1:0]           rem_q;
	logic                      neg_q;
	logic                      ovf_q;
	logic [A0_W:0]             trial;
	logic [A0_W-1:0]           rem_nx;
	logic [QUO_W-1:0]          sh_nx;
	logic                      qbit;

	logic [QUO_W-1:0]          lim;
	logic                      sat;
	logic [STATE_W-1:0]        mag;
	logic [STATE_W-1:0]        y_new;
	logic [OUTM_W-1:0]         outm;
	logic signed [SMP_W-1:0]   res_c;

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (ctl.step)
			STEP_B0: begin
				op_a = coef.b0;
				op_b = {{(OPB_W-SMP_W){smp_q[ctl.ch][SMP_W-1]}}, smp_q[ctl.ch]};
			end
			STEP_B2: begin
				op_a = coef.b2;
				op_b = {{(OPB_W-SMP_W){xh_q[ctl.ch][1][SMP_W-1]}}, xh_q[ctl.ch][1]};
			end
			STEP_A1_LO: begin
				op_a = coef.a1;
				op_b = {1'b0, yh_q[ctl.ch][0][HALF_W-1:0]};
			end
			STEP_A1_HI: begin
				op_a = coef.a1;
				op_b = {yh_q[ctl.ch][0][STATE_W-1], yh_q[ctl.ch][0][STATE_W-1:HALF_W]};
			end
			STEP_A2_LO: begin
				op_a = coef.a2;
				op_b = {1'b0, yh_q[ctl.ch][1][HALF_W-1:0]};
			end
			STEP_A2_HI: begin
				op_a = coef.a2;
				op_b = {yh_q[ctl.ch][1][STATE_W-1], yh_q[ctl.ch][1][STATE_W-1:HALF_W]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1      <= prod;
		prod_step_s1 <= ctl.step;
	end

	// align the product to 36 fraction bits and pick add or subtract
	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	always_comb begin
		term = prod_ext;
		sub  = 1'b0;
		case (prod_step_s1) inside
			STEP_B0, STEP_B2: begin
				term = prod_ext <<< FRAC_W;
			end
			STEP_A1_HI, STEP_A2_HI: begin
				term = prod_ext <<< HALF_W;
				sub  = 1'b1;
			end
			STEP_A1_LO, STEP_A2_LO: begin
				sub  = 1'b1;
			end
			default: begin
				term = prod_ext;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= sub ? acc_q - term : acc_q + term;
		end
	end

	// magnitude, divisor and early overflow test
	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
	assign dvs     = (coef.a0 == '0) ? A0_W'(1) : coef.a0;
	assign ovf_c   = {{(A0_W-TOP_W){1'b0}}, acc_abs[MAG_W-1:QUO_W]} >= dvs;

	// four restoring division steps per cycle
	always_comb begin
		rem_nx = rem_q;
		sh_nx  = shreg_q;
		trial  = '0;
		qbit   = 1'b0;
		for (int i = 0; i < RADIX_BITS; i++) begin
			trial = {rem_nx, sh_nx[QUO_W-1]};
			if (trial >= {1'b0, dvs}) begin
				rem_nx = A0_W'(trial - {1'b0, dvs});
				qbit   = 1'b1;
			end else begin
				rem_nx = trial[A0_W-1:0];
				qbit   = 1'b0;
			end
			sh_nx = {sh_nx[QUO_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.chk) begin
			neg_q   <= acc_q[ACC_W-1];
			ovf_q   <= ovf_c;
			shreg_q <= acc_abs[QUO_W-1:0];
			rem_q   <= ovf_c ? '0 : {{(A0_W-TOP_W){1'b0}}, acc_abs[MAG_W-1:QUO_W]};
		end else if (ctl.div_en) begin
			shreg_q <= sh_nx;
			rem_q   <= rem_nx;
		end
	end

	// state saturation, sign restore and output clamp
	always_comb begin
		lim   = {{(QUO_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}} + QUO_W'(neg_q);
		sat   = ovf_q || (shreg_q > lim);
		mag   = sat ? lim[STATE_W-1:0] : shreg_q[STATE_W-1:0];
		y_new = neg_q ? STATE_W'(-mag) : mag;
		outm  = mag[STATE_W-1:FRAC_W];
		if (neg_q) begin
			if (outm > OUT_NEG_MAG) begin
				outm = OUT_NEG_MAG;
			end
			res_c = SMP_W'(-outm);
		end else begin
			if (outm > OUT_POS_MAX) begin
				outm = OUT_POS_MAX;
			end
			res_c = outm[SMP_W-1:0];
		end
	end

	// sample capture and result words
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			smp_q[0] <= left_sample;
			smp_q[1] <= right_sample;
		end
		if (ctl.wb) begin
			res_q[ctl.ch] <= res_c;
		end
	end

	// filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				xh_q[c][0] <= '0;
				xh_q[c][1] <= '0;
				yh_q[c][0] <= '0;
				yh_q[c][1] <= '0;
			end
		end else if (ctl.wb) begin
			xh_q[ctl.ch][1] <= xh_q[ctl.ch][0];
			xh_q[ctl.ch][0] <= smp_q[ctl.ch];
			yh_q[ctl.ch][1] <= yh_q[ctl.ch][0];
			yh_q[ctl.ch][0] <= y_new;
		end
	end

	assign left_res  = res_q[0];
	assign right_res = res_q[1];

endmodule

FILE: rtl/core/sbq_seq.sv
// Sequencer for the stereo biquad: multiply, accumulate, check, divide and
// write-back steps per channel, then the output hand-over. Depends on sbq_pkg.
module sbq_seq import sbq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_free,
	output logic     in_ready,
	output logic     out_load,
	output sbq_ctl_t ctl
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;
	localparam logic [2:0] S_PUT  = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ch_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ch_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
						ch_q    <= 1'b0;
					end
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(STEP_LAST)) begin
						state_q <= S_ACC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ACC: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_WB;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_WB: begin
					if (!ch_q) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
						ch_q    <= 1'b1;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// control word to the datapath
	assign in_ready   = (state_q == S_IDLE);
	assign out_load   = (state_q == S_PUT) && out_free;
	assign ctl.load   = in_ready && in_valid;
	assign ctl.clr    = in_ready || (state_q == S_WB);
	assign ctl.mul_en = (state_q == S_MUL);
	assign ctl.step   = cnt_q[STEP_W-1:0];
	assign ctl.chk    = (state_q == S_CHK);
	assign ctl.div_en = (state_q == S_DIV);
	assign ctl.wb     = (state_q == S_WB);
	assign ctl.ch     = ch_q;

endmodule

FILE: rtl/core/stereo_biquad_audio_filter_top.sv
// Top level of the stereo biquad filter: coefficient registers, output word
// register, sequencer and datapath. Depends on sbq_pkg, sbq_seq, sbq_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_ready  | left_sample, right_sample, packet_end
//   output   | out_valid / out_ready| left_out, right_out, packet_end_out
//   config   | cfg_we               | cfg_index, cfg_data
//
// in_ready stays low from a taken frame until its word is handed over, so a new
// frame is not taken while the last one is still being filtered. Per channel:
// six passes through the shared 24x25 multiplier, one accumulate drain, one
// magnitude/overflow check, thirteen radix-16 divider steps and one write-back;
// then the word is handed over. The divider loop takes the longest per channel.
// Reset clears the history, the sequencer and the output valid; a0 resets to 1.0.
// A stalled output word holds while the next frame is already being filtered;
// the finished frame waits in the sequencer until the output register frees.
module stereo_biquad_audio_filter_top import sbq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [SMP_W-1:0] left_sample,
	input  logic signed [SMP_W-1:0] right_sample,
	input  logic                    packet_end,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SMP_W-1:0] left_out,
	output logic signed [SMP_W-1:0] right_out,
	output logic                    packet_end_out,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [COEF_W-1:0]       cfg_data
);

	sbq_coef_t               coef_q;
	sbq_ctl_t                ctl;
	logic                    out_load;
	logic                    out_free;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] left_out_q;
	logic signed [SMP_W-1:0] right_out_q;
	logic                    pe_out_q;
	logic                    pe_q;
	logic signed [SMP_W-1:0] left_res;
	logic signed [SMP_W-1:0] right_res;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a0 <= A0_RESET;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
			coef_q.b0 <= '0;
			coef_q.b2 <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A0:  coef_q.a0 <= cfg_data[A0_W-1:0];
				REG_A1:  coef_q.a1 <= cfg_data;
				REG_A2:  coef_q.a2 <= cfg_data;
				REG_B0:  coef_q.b0 <= cfg_data;
				REG_B2:  coef_q.b2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// packet end mark rides along with the frame
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pe_q <= packet_end;
		end
	end

	sbq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_ready (in_ready),
		.out_load (out_load),
		.ctl      (ctl)
	);

	sbq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.coef         (coef_q),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.left_res     (left_res),
		.right_res    (right_res)
	);

	// output word register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_out_q  <= left_res;
			right_out_q <= right_res;
			pe_out_q    <= pe_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_out       = left_out_q;
	assign right_out      = right_out_q;
	assign packet_end_out = pe_out_q;

endmodule

FILE: rtl/core/sbq_checker.sv
// Port-level checks for the stereo biquad top level, bound to it below.
// Depends on sbq_pkg and stereo_biquad_audio_filter_top.
module sbq_checker import sbq_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [SMP_W-1:0] left_out,
	input logic signed [SMP_W-1:0] right_out,
	input logic                    packet_end_out
);

	// a taken frame keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after a frame was taken");

	// a new output word only appears at the end of a busy stretch
	a_word_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output word appeared while the block was idle");

	// the block frees its input only after handing over the word
	a_ready_with_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("input freed without an output word");

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(left_out)
			&& $stable(right_out) && $stable(packet_end_out)))
		else $error("stalled output word changed");

endmodule

bind stereo_biquad_audio_filter_top sbq_checker u_sbq_checker (.*);
